// File: sv/csp_pkg.sv
package csp_pkg;

    localparam int NW = 6;
    localparam int DVW = 19;
    localparam int FW = 17;
    localparam int FRAC = 13;

    localparam logic [NW-1:0] MAX_STEPS = 6'd63;
    localparam logic [NW-1:0] STEPS_RESET = 6'd16;
    localparam logic signed [15:0] TENSION_RESET = 16'sd0;
    localparam logic signed [FW-1:0] ONE_Q12 = 17'sd4096;

    localparam logic [0:0] CFG_TENSION = 1'b0;
    localparam logic [0:0] CFG_STEPS = 1'b1;

    localparam logic [1:0] WINDOW_FULL = 2'd3;

    typedef enum logic [2:0] {
        FR_IDLE,
        FR_TAN_A,
        FR_TAN_B,
        FR_COEF,
        FR_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_N2,
        BK_N3,
        BK_MUL,
        BK_DIFF,
        BK_DIV,
        BK_DIV_WAIT,
        BK_RUN
    } back_state_t;

endpackage

// File: sv/csp_fifo.sv
module csp_fifo #(
    parameter int W = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  logic [W-1:0] wr_data,
    input  logic         pop,
    output logic [W-1:0] rd_data,
    output logic         full,
    output logic         empty
);

    logic [W-1:0] mem_reg [2];
    logic         wptr_reg, wptr_next;
    logic         rptr_reg, rptr_next;
    logic [1:0]   cnt_reg, cnt_next;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign rd_data = mem_reg[rptr_reg];

    always_comb begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (push && !full) begin
            wptr_next = ~wptr_reg;
        end
        if (pop && !empty) begin
            rptr_next = ~rptr_reg;
        end
        if ((push && !full) && !(pop && !empty)) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (!(push && !full) && (pop && !empty)) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push && !full) begin
            mem_reg[wptr_reg] <= wr_data;
        end
    end

endmodule

// File: sv/csp_front.sv
module csp_front #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_WIDTH-1:0] point_x,
    input  logic signed [COORD_WIDTH-1:0] point_y,
    input  logic                          starts_curve,
    input  logic signed [15:0]            tension,
    input  logic [csp_pkg::NW-1:0]        steps,
    output logic                          job_push,
    input  logic                          job_full,
    output logic [2*(2*(COORD_WIDTH+8)+COORD_WIDTH+5+COORD_WIDTH)+csp_pkg::NW-1:0] job_data
);

    localparam int PW = COORD_WIDTH;
    localparam int DW = PW + 1;
    localparam int UW = PW + 5;
    localparam int CW = PW + 8;
    localparam int AXW = 2 * CW + UW + PW;
    localparam int JW = 2 * AXW + csp_pkg::NW;

    csp_pkg::front_state_t state_reg, state_next;

    logic [1:0]                   held_reg;
    logic signed [PW-1:0]         wx_reg [3];
    logic signed [PW-1:0]         wy_reg [3];
    logic signed [DW-1:0]         dx0_reg, dy0_reg, dx1_reg, dy1_reg;
    logic signed [PW-1:0]         p1x_reg, p2x_reg, p1y_reg, p2y_reg;
    logic signed [csp_pkg::FW-1:0] f_reg;
    logic [csp_pkg::NW-1:0]       n_reg;
    logic signed [UW-1:0]         ux1_reg, uy1_reg, ux2_reg, uy2_reg;
    logic [JW-1:0]                job_reg;
    logic [1:0]                   held_eff;
    logic                         accept;

    function automatic logic signed [UW-1:0] tangent(input logic signed [DW-1:0] d,
                                                     input logic signed [csp_pkg::FW-1:0] f);
        logic signed [DW+csp_pkg::FW-1:0] prod;
        prod = d * f;
        prod = prod + (DW + csp_pkg::FW)'(4096);
        return prod[DW+csp_pkg::FW-1:csp_pkg::FRAC];
    endfunction

    function automatic logic [AXW-1:0] coefs(input logic signed [PW-1:0] p1,
                                             input logic signed [UW-1:0] u1,
                                             input logic signed [PW-1:0] p2,
                                             input logic signed [UW-1:0] u2);
        logic signed [CW-1:0] e1, e2, v1, v2, dp, c0, c1;
        e1 = CW'(p1);
        e2 = CW'(p2);
        v1 = CW'(u1);
        v2 = CW'(u2);
        dp = e2 - e1;
        c0 = (e1 <<< 1) + v1 - (e2 <<< 1) + v2;
        c1 = dp + (dp <<< 1) - (v1 <<< 1) - v2;
        return {p1, u1, c1, c0};
    endfunction

    assign in_ready = (state_reg == csp_pkg::FR_IDLE);
    assign accept   = in_valid && in_ready;
    assign job_push = (state_reg == csp_pkg::FR_PUSH) && !job_full;
    assign job_data = job_reg;
    assign held_eff = starts_curve ? 2'd0 : held_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            csp_pkg::FR_IDLE: begin
                if (accept && held_eff == csp_pkg::WINDOW_FULL) begin
                    state_next = csp_pkg::FR_TAN_A;
                end
            end
            csp_pkg::FR_TAN_A: state_next = csp_pkg::FR_TAN_B;
            csp_pkg::FR_TAN_B: state_next = csp_pkg::FR_COEF;
            csp_pkg::FR_COEF:  state_next = csp_pkg::FR_PUSH;
            csp_pkg::FR_PUSH: begin
                if (!job_full) begin
                    state_next = csp_pkg::FR_IDLE;
                end
            end
            default: state_next = csp_pkg::FR_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= csp_pkg::FR_IDLE;
            held_reg  <= 2'd0;
            for (int i = 0; i < 3; i++) begin
                wx_reg[i] <= '0;
                wy_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (accept) begin
                if (held_eff != csp_pkg::WINDOW_FULL) begin
                    wx_reg[held_eff] <= point_x;
                    wy_reg[held_eff] <= point_y;
                    held_reg         <= held_eff + 2'd1;
                end else begin
                    wx_reg[0] <= wx_reg[1];
                    wx_reg[1] <= wx_reg[2];
                    wx_reg[2] <= point_x;
                    wy_reg[0] <= wy_reg[1];
                    wy_reg[1] <= wy_reg[2];
                    wy_reg[2] <= point_y;
                    held_reg  <= held_eff;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            csp_pkg::FR_IDLE: begin
                if (accept) begin
                    dx0_reg <= DW'(wx_reg[2]) - DW'(wx_reg[0]);
                    dy0_reg <= DW'(wy_reg[2]) - DW'(wy_reg[0]);
                    dx1_reg <= DW'(point_x) - DW'(wx_reg[1]);
                    dy1_reg <= DW'(point_y) - DW'(wy_reg[1]);
                    p1x_reg <= wx_reg[1];
                    p2x_reg <= wx_reg[2];
                    p1y_reg <= wy_reg[1];
                    p2y_reg <= wy_reg[2];
                    f_reg   <= csp_pkg::ONE_Q12 - csp_pkg::FW'(tension);
                    if (steps == '0) begin
                        n_reg <= csp_pkg::NW'(1);
                    end else if (steps > csp_pkg::MAX_STEPS) begin
                        n_reg <= csp_pkg::MAX_STEPS;
                    end else begin
                        n_reg <= steps;
                    end
                end
            end
            csp_pkg::FR_TAN_A: begin
                ux1_reg <= tangent(dx0_reg, f_reg);
                uy1_reg <= tangent(dy0_reg, f_reg);
            end
            csp_pkg::FR_TAN_B: begin
                ux2_reg <= tangent(dx1_reg, f_reg);
                uy2_reg <= tangent(dy1_reg, f_reg);
            end
            csp_pkg::FR_COEF: begin
                job_reg <= {n_reg,
                            coefs(p1y_reg, uy1_reg, p2y_reg, uy2_reg),
                            coefs(p1x_reg, ux1_reg, p2x_reg, ux2_reg)};
            end
            default: ;
        endcase
    end

endmodule

// File: sv/csp_div.sv
module csp_div #(
    parameter int AW = 38
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic signed [AW-1:0]       dividend,
    input  logic [csp_pkg::DVW-1:0]    divisor,
    output logic                       done,
    output logic signed [AW-1:0]       quot,
    output logic [csp_pkg::DVW-1:0]    rem
);

    localparam int CNW = $clog2(AW + 1);

    logic [CNW-1:0]              cnt_reg;
    logic                        done_reg;
    logic                        neg_reg;
    logic [AW-1:0]               quo_reg;
    logic [csp_pkg::DVW-1:0]     rem_reg;
    logic [csp_pkg::DVW:0]       trial;

    assign trial = {rem_reg, quo_reg[AW-1]};
    assign done  = done_reg;

    always_comb begin
        if (neg_reg && rem_reg != '0) begin
            quot = -$signed(quo_reg) - AW'(1);
            rem  = divisor - rem_reg;
        end else if (neg_reg) begin
            quot = -$signed(quo_reg);
            rem  = rem_reg;
        end else begin
            quot = $signed(quo_reg);
            rem  = rem_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= (cnt_reg == CNW'(1));
            if (start) begin
                cnt_reg <= CNW'(AW);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - CNW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg <= dividend[AW-1];
            quo_reg <= dividend[AW-1] ? AW'(-dividend) : AW'(dividend);
            rem_reg <= '0;
        end else if (cnt_reg != '0) begin
            if (trial >= {1'b0, divisor}) begin
                rem_reg <= csp_pkg::DVW'(trial - {1'b0, divisor});
                quo_reg <= {quo_reg[AW-2:0], 1'b1};
            end else begin
                rem_reg <= trial[csp_pkg::DVW-1:0];
                quo_reg <= {quo_reg[AW-2:0], 1'b0};
            end
        end
    end

endmodule

// File: sv/csp_back.sv
module csp_back #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          job_empty,
    output logic                          job_pop,
    input  logic [2*(2*(COORD_WIDTH+8)+COORD_WIDTH+5+COORD_WIDTH)+csp_pkg::NW-1:0] job_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [COORD_WIDTH-1:0] pixel_x,
    output logic signed [COORD_WIDTH-1:0] pixel_y,
    output logic                          last_of_segment
);

    localparam int PW = COORD_WIDTH;
    localparam int UW = PW + 5;
    localparam int CW = PW + 8;
    localparam int AXW = 2 * CW + UW + PW;
    localparam int AW = PW + 22;
    localparam int A1W = CW + csp_pkg::NW + 1;
    localparam int BW = UW + 2 * csp_pkg::NW + 1;
    localparam int DVW = csp_pkg::DVW;
    localparam logic signed [AW-1:0] HI = AW'((64'sd1 <<< (PW - 1)) - 64'sd1);
    localparam logic signed [AW-1:0] LO = -HI - AW'(1);

    csp_pkg::back_state_t state_reg, state_next;

    logic signed [CW-1:0]          c0x_reg, c1x_reg, c0y_reg, c1y_reg;
    logic signed [UW-1:0]          c2x_reg, c2y_reg;
    logic signed [PW-1:0]          c3x_reg, c3y_reg;
    logic [csp_pkg::NW-1:0]        n_reg, k_reg;
    logic [2*csp_pkg::NW-1:0]      n2_reg;
    logic [3*csp_pkg::NW-1:0]      n3_reg;
    logic signed [A1W-1:0]         a1x_reg, a1y_reg;
    logic signed [BW-1:0]          bx_reg, by_reg;
    logic signed [AW-1:0]          dvd_reg [6];
    logic [2:0]                    idx_reg;
    logic signed [AW-1:0]          dq_reg [6];
    logic [DVW-1:0]                dr_reg [6];
    logic signed [AW-1:0]          mqx_reg, mqy_reg;
    logic [DVW-1:0]                mrx_reg, mry_reg;
    logic                          out_valid_reg;
    logic signed [PW-1:0]          px_reg, py_reg;
    logic                          last_reg;
    logic [DVW-1:0]                two_d;
    logic                          out_free;
    logic                          emit;
    logic                          div_start, div_done;
    logic signed [AW-1:0]          div_q;
    logic [DVW-1:0]                div_r;
    logic [AW+DVW-1:0]             sx0, sx1, sx2, sy0, sy1, sy2;

    function automatic logic [AW+DVW-1:0] add_qr(input logic signed [AW-1:0] q1,
                                                input logic [DVW-1:0] r1,
                                                input logic signed [AW-1:0] q2,
                                                input logic [DVW-1:0] r2,
                                                input logic [DVW-1:0] d);
        logic [DVW:0] s;
        s = {1'b0, r1} + {1'b0, r2};
        if (s >= {1'b0, d}) begin
            return {q1 + q2 + AW'(1), DVW'(s - {1'b0, d})};
        end
        return {q1 + q2, s[DVW-1:0]};
    endfunction

    function automatic logic signed [PW-1:0] sat(input logic signed [AW-1:0] v);
        if (v > HI) begin
            return PW'(HI);
        end
        if (v < LO) begin
            return PW'(LO);
        end
        return v[PW-1:0];
    endfunction

    assign two_d     = {n3_reg, 1'b0};
    assign out_free  = !out_valid_reg || out_ready;
    assign emit      = (state_reg == csp_pkg::BK_RUN) && out_free;
    assign job_pop   = (state_reg == csp_pkg::BK_IDLE) && !job_empty;
    assign div_start = (state_reg == csp_pkg::BK_DIV);

    assign out_valid       = out_valid_reg;
    assign pixel_x         = px_reg;
    assign pixel_y         = py_reg;
    assign last_of_segment = last_reg;

    assign sx0 = add_qr(mqx_reg, mrx_reg, dq_reg[0], dr_reg[0], two_d);
    assign sx1 = add_qr(dq_reg[0], dr_reg[0], dq_reg[1], dr_reg[1], two_d);
    assign sx2 = add_qr(dq_reg[1], dr_reg[1], dq_reg[2], dr_reg[2], two_d);
    assign sy0 = add_qr(mqy_reg, mry_reg, dq_reg[3], dr_reg[3], two_d);
    assign sy1 = add_qr(dq_reg[3], dr_reg[3], dq_reg[4], dr_reg[4], two_d);
    assign sy2 = add_qr(dq_reg[4], dr_reg[4], dq_reg[5], dr_reg[5], two_d);

    csp_div #(
        .AW(AW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dvd_reg[idx_reg]),
        .divisor  (two_d),
        .done     (div_done),
        .quot     (div_q),
        .rem      (div_r)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            csp_pkg::BK_IDLE: begin
                if (!job_empty) begin
                    state_next = csp_pkg::BK_N2;
                end
            end
            csp_pkg::BK_N2:   state_next = csp_pkg::BK_N3;
            csp_pkg::BK_N3:   state_next = csp_pkg::BK_MUL;
            csp_pkg::BK_MUL:  state_next = csp_pkg::BK_DIFF;
            csp_pkg::BK_DIFF: state_next = csp_pkg::BK_DIV;
            csp_pkg::BK_DIV:  state_next = csp_pkg::BK_DIV_WAIT;
            csp_pkg::BK_DIV_WAIT: begin
                if (div_done) begin
                    state_next = (idx_reg == 3'd5) ? csp_pkg::BK_RUN : csp_pkg::BK_DIV;
                end
            end
            csp_pkg::BK_RUN: begin
                if (emit && k_reg == n_reg) begin
                    state_next = csp_pkg::BK_IDLE;
                end
            end
            default: state_next = csp_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= csp_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            csp_pkg::BK_IDLE: begin
                if (!job_empty) begin
                    {c3x_reg, c2x_reg, c1x_reg, c0x_reg} <= job_data[AXW-1:0];
                    {c3y_reg, c2y_reg, c1y_reg, c0y_reg} <= job_data[2*AXW-1:AXW];
                    n_reg <= job_data[2*AXW+csp_pkg::NW-1:2*AXW];
                end
            end
            csp_pkg::BK_N2: begin
                n2_reg <= n_reg * n_reg;
            end
            csp_pkg::BK_N3: begin
                n3_reg <= n2_reg * n_reg;
            end
            csp_pkg::BK_MUL: begin
                a1x_reg <= c1x_reg * $signed({1'b0, n_reg});
                a1y_reg <= c1y_reg * $signed({1'b0, n_reg});
                bx_reg  <= c2x_reg * $signed({1'b0, n2_reg});
                by_reg  <= c2y_reg * $signed({1'b0, n2_reg});
            end
            csp_pkg::BK_DIFF: begin
                dvd_reg[0] <= (AW'(c0x_reg) + AW'(a1x_reg) + AW'(bx_reg)) <<< 1;
                dvd_reg[1] <= (AW'(c0x_reg) <<< 3) + (AW'(c0x_reg) <<< 2)
                              + (AW'(a1x_reg) <<< 2);
                dvd_reg[2] <= (AW'(c0x_reg) <<< 3) + (AW'(c0x_reg) <<< 2);
                dvd_reg[3] <= (AW'(c0y_reg) + AW'(a1y_reg) + AW'(by_reg)) <<< 1;
                dvd_reg[4] <= (AW'(c0y_reg) <<< 3) + (AW'(c0y_reg) <<< 2)
                              + (AW'(a1y_reg) <<< 2);
                dvd_reg[5] <= (AW'(c0y_reg) <<< 3) + (AW'(c0y_reg) <<< 2);
                idx_reg    <= 3'd0;
            end
            csp_pkg::BK_DIV_WAIT: begin
                if (div_done) begin
                    dq_reg[idx_reg] <= div_q;
                    dr_reg[idx_reg] <= div_r;
                    idx_reg         <= idx_reg + 3'd1;
                    mqx_reg         <= AW'(c3x_reg);
                    mqy_reg         <= AW'(c3y_reg);
                    mrx_reg         <= DVW'(n3_reg);
                    mry_reg         <= DVW'(n3_reg);
                    k_reg           <= '0;
                end
            end
            csp_pkg::BK_RUN: begin
                if (emit) begin
                    px_reg   <= sat(mqx_reg);
                    py_reg   <= sat(mqy_reg);
                    last_reg <= (k_reg == n_reg);
                    k_reg    <= k_reg + csp_pkg::NW'(1);
                    {mqx_reg, mrx_reg}     <= sx0;
                    {dq_reg[0], dr_reg[0]} <= sx1;
                    {dq_reg[1], dr_reg[1]} <= sx2;
                    {mqy_reg, mry_reg}     <= sy0;
                    {dq_reg[3], dr_reg[3]} <= sy1;
                    {dq_reg[4], dr_reg[4]} <= sy2;
                end
            end
            default: ;
        endcase
    end

endmodule

// File: sv/cardinal_spline_points.sv
// Cardinal spline pixel generator. Control points enter one request at a time; the
// first three of a curve are only stored. Each further point yields one segment of
// n+1 pixels (n = points_per_segment, 0 read as 1), the last one flagged by m_tlast.
// A point that starts a segment passes the tangent, coefficient and push states,
// push stalling on a full queue; two segments can wait in the queue before the
// pixel engine. It sets up each segment with six passes of one bit-serial divider,
// then emits one pixel per cycle unless m_tready stalls it, by forward differencing.
// Configuration writes are meant for idle periods only.
module cardinal_spline_points #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // point_x, point_y
    input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]     s_tdata,
    // starts_curve
    input  logic [0:0]                             s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // pixel_x, pixel_y
    output logic [((2*COORD_WIDTH+7)/8)*8-1:0]     m_tdata,
    output logic                                   m_tlast,
    input  logic                                   cfg_wr_en,
    input  logic [0:0]                             cfg_addr,
    input  logic [15:0]                            cfg_wdata
);

    localparam int OW = ((2 * COORD_WIDTH + 7) / 8) * 8;
    localparam int JW = 2 * (2 * (COORD_WIDTH + 8) + COORD_WIDTH + 5 + COORD_WIDTH)
                        + csp_pkg::NW;

    logic signed [15:0]               tension_reg;
    logic [csp_pkg::NW-1:0]           steps_reg;
    logic                             job_push, job_pop, fifo_full, fifo_empty;
    logic [JW-1:0]                    job_in, job_out;
    logic signed [COORD_WIDTH-1:0]    pixel_x, pixel_y;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tension_reg <= csp_pkg::TENSION_RESET;
            steps_reg   <= csp_pkg::STEPS_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                csp_pkg::CFG_TENSION: tension_reg <= cfg_wdata;
                csp_pkg::CFG_STEPS:   steps_reg   <= cfg_wdata[csp_pkg::NW-1:0];
                default: ;
            endcase
        end
    end

    csp_front #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .point_x      (s_tdata[COORD_WIDTH-1:0]),
        .point_y      (s_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
        .starts_curve (s_tuser[0]),
        .tension      (tension_reg),
        .steps        (steps_reg),
        .job_push     (job_push),
        .job_full     (fifo_full),
        .job_data     (job_in)
    );

    csp_fifo #(
        .W(JW)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (job_push),
        .wr_data (job_in),
        .pop     (job_pop),
        .rd_data (job_out),
        .full    (fifo_full),
        .empty   (fifo_empty)
    );

    csp_back #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .job_empty       (fifo_empty),
        .job_pop         (job_pop),
        .job_data        (job_out),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .pixel_x         (pixel_x),
        .pixel_y         (pixel_y),
        .last_of_segment (m_tlast)
    );

    assign m_tdata = OW'({pixel_y, pixel_x});

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        job_push |-> !fifo_full) else $error("segment queue overflow");

    a_queue_count: assert property (@(posedge aclk) disable iff (!aresetn)
        !(fifo_empty && fifo_full)) else $error("segment queue both empty and full");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid) else $error("pixel valid after reset");
`endif

endmodule

// File: tb/sv/tb_cardinal_spline_points.sv
`timescale 1ns / 1ps

class spline_scoreboard;
    int signed tension;
    int unsigned steps;
    longint signed win_x[3];
    longint signed win_y[3];
    int unsigned held;
    logic [32:0] pending_pixels[$];
    int errors;

    function new();
        reset_state();
        errors = 0;
    endfunction

    function void reset_state();
        tension = 0;
        steps = 16;
        held = 0;
        for (int i = 0; i < 3; i++) begin
            win_x[i] = 0;
            win_y[i] = 0;
        end
    endfunction

    function void write_reg(logic [0:0] idx, logic [15:0] val);
        if (idx == csp_pkg::CFG_TENSION) tension = $signed(val);
        else steps = val[5:0];
    endfunction

    function longint signed fdiv(longint signed num, longint signed den);
        longint signed q;
        q = num / den;
        if ((num % den) != 0 && num < 0) q--;
        return q;
    endfunction

    function longint signed slope(longint signed d);
        return fdiv(d * (4096 - tension) + 4096, 8192);
    endfunction

    function logic [15:0] clip(longint signed v);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    function logic [15:0] pixel_at(longint signed p0, longint signed p1, longint signed p2,
                                   longint signed p3, longint signed k, longint signed n);
        longint signed u1, u2, c0, c1, n3, num;
        u1 = slope(p2 - p0);
        u2 = slope(p3 - p1);
        c0 = 2 * p1 + u1 - 2 * p2 + u2;
        c1 = -3 * p1 - 2 * u1 + 3 * p2 - u2;
        n3 = n * n * n;
        num = c0 * k * k * k + c1 * k * k * n + u1 * k * n * n + p1 * n3;
        return clip(fdiv(2 * num + n3, 2 * n3));
    endfunction

    function void note_point(logic [15:0] x, logic [15:0] y, logic starts);
        longint signed px, py, n;
        px = $signed(x);
        py = $signed(y);
        if (starts) held = 0;
        if (held < 3) begin
            win_x[held] = px;
            win_y[held] = py;
            held++;
            return;
        end
        n = (steps < 1) ? 1 : steps;
        for (longint signed k = 0; k <= n; k++) begin
            pending_pixels.push_back({k == n,
                pixel_at(win_y[0], win_y[1], win_y[2], py, k, n),
                pixel_at(win_x[0], win_x[1], win_x[2], px, k, n)});
        end
        win_x[0] = win_x[1]; win_x[1] = win_x[2]; win_x[2] = px;
        win_y[0] = win_y[1]; win_y[1] = win_y[2]; win_y[2] = py;
    endfunction

    task report(string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    task check_pixel(logic [31:0] data, logic last);
        logic [32:0] want;
        if (pending_pixels.size() == 0) begin
            report($sformatf("unexpected pixel %h last %0b", data, last));
            return;
        end
        want = pending_pixels.pop_front();
        if (data[15:0] !== want[15:0])
            report($sformatf("pixel_x got %h want %h", data[15:0], want[15:0]));
        if (data[31:16] !== want[31:16])
            report($sformatf("pixel_y got %h want %h", data[31:16], want[31:16]));
        if (last !== want[32])
            report($sformatf("last_of_segment got %0b want %0b", last, want[32]));
    endtask
endclass

module tb_cardinal_spline_points;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [31:0] s_tdata = '0;
    logic [0:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic m_tlast;
    logic cfg_wr_en = 1'b0;
    logic [0:0] cfg_addr = '0;
    logic [15:0] cfg_wdata = '0;

    spline_scoreboard board = new();
    bit calm = 1'b0;
    longint unsigned cycles = 0;

    cardinal_spline_points i_dut (.*);

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 3000000) begin
            $display("** cardinal_spline_points: FAILED **");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_pixel(m_tdata, m_tlast);
    end

    initial begin
        int gap;
        forever begin
            @(posedge aclk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 13);
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    task automatic write_reg(logic [0:0] idx, logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        board.write_reg(idx, val);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_point(logic [15:0] x, logic [15:0] y, logic starts);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {y, x};
        s_tuser <= starts;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_point(x, y, starts);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending_pixels.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            default: return 16'($urandom_range(0, 400)) - 16'd200;
        endcase
    endfunction

    task automatic random_points(int count);
        for (int i = 0; i < count; i++)
            send_point(rand_coord(), rand_coord(), $urandom_range(0, 11) == 0);
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_point(16'd0, 16'd0, 1'b1);
        send_point(16'd100, 16'd50, 1'b0);
        send_point(16'd200, 16'hff00, 1'b0);
        send_point(16'd300, 16'd10, 1'b0);
        send_point(16'h7fff, 16'h8000, 1'b0);
        send_point(16'h8000, 16'h7fff, 1'b0);
        send_point(16'h7fff, 16'h8000, 1'b0);
        send_point(16'hffff, 16'hffff, 1'b1);
        send_point(16'h5555, 16'haaaa, 1'b0);
        drain();

        write_reg(csp_pkg::CFG_STEPS, 16'd0);
        write_reg(csp_pkg::CFG_TENSION, 16'h8000);
        send_point(16'h8000, 16'h8000, 1'b1);
        send_point(16'h7fff, 16'h7fff, 1'b0);
        send_point(16'h8000, 16'h8000, 1'b0);
        send_point(16'h7fff, 16'h7fff, 1'b0);
        send_point(16'haaaa, 16'h5555, 1'b0);
        drain();

        write_reg(csp_pkg::CFG_STEPS, 16'hffff);
        write_reg(csp_pkg::CFG_TENSION, 16'h7fff);
        send_point(16'd1, 16'd2, 1'b1);
        send_point(16'd3, 16'd4, 1'b0);
        send_point(16'd5, 16'd6, 1'b0);
        send_point(16'h8000, 16'h7fff, 1'b0);
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            write_reg(csp_pkg::CFG_STEPS,
                      16'($urandom_range(0, 12)) | (16'($urandom) & 16'hffc0));
            write_reg(csp_pkg::CFG_TENSION, 16'($urandom));
            if (phase == 5) calm = 1'b1;
            random_points(25);
            drain();
        end

        if (board.pending_pixels.size() == 0 && board.errors == 0)
            $display("** cardinal_spline_points: PASSED **");
        else
            $display("** cardinal_spline_points: FAILED **");
        $finish;
    end
endmodule
